// ===== src/ovl_pkg.sv =====
`timescale 1ns / 1ps

package ovl_pkg;

   // List geometry.
   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STAT_W   = 2;
   localparam int POS_W    = 6;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MATCH     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [DATA_W-1:0] value;
   } ovl_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  length;
      logic              last;
   } ovl_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FINAL = 3'b100
   } ovl_state_type;

endpackage

// ===== src/ovl_ram.sv =====
`timescale 1ns / 1ps

module ovl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ordered_value_list.sv =====
`timescale 1ns / 1ps

// Ordered value list: up to CAPACITY signed 32-bit values kept in insertion order.
// A request beat is taken at a rising edge where start is high and busy is low; it
// carries an operation (append, find all, remove first match) and a value.
// Every request gives one or more response beats on rsp_item, each marked by
// rsp_strobe for exactly one cycle; the final beat of a request has last set.
// Append, an unused code, and a find or remove on an empty list answer in the
// cycle after the request, and busy never rises.
// Find and remove walk the stored entries through the single RAM read port, one
// entry per cycle; busy stays high through the walk and falls when the final beat is shown.
// Each find report but the last is shown in the cycle after the next matching entry
// is compared; the last report is the final beat.
// Remove copies every later entry up one place during the same walk.
// A new request may be taken in the cycle the final beat is shown.
// Reset (synchronous, active high) empties the list and drops any pending beat.
// The receiver cannot stall: each beat is taken in the cycle it is shown.

module ordered_value_list
   import ovl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ovl_req_type req_item,
   output logic        rsp_strobe,
   output ovl_rsp_type rsp_item
);

   ovl_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     dv_ff, dv_in;
   logic [ADDR_W-1:0]        da_ff, da_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [DATA_W-1:0]        key_ff, key_in;
   logic                     found_ff, found_in;
   logic [POS_W-1:0]         pend_pos_ff, pend_pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ovl_rsp_type              rsp_ff, rsp_in;

   logic                     issue;
   logic                     finish;
   logic                     match;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [DATA_W-1:0]        rd_data;

   // Entry storage.
   ovl_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (issue),
      .rd_addr(rd_idx_ff[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   // Walk control: one read issued per cycle, its data compared in the cycle after.
   assign issue  = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff);
   assign match  = dv_ff && (rd_data == key_ff);
   assign finish = dv_ff && ({1'b0, da_ff} == (count_ff - CNT_W'(1)));

   // Sequencer and response generation.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      dv_in        = issue;
      da_in        = rd_idx_ff[ADDR_W-1:0];
      op_in        = op_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      pend_pos_in  = pend_pos_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req_item.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in           = req_item.operation;
               key_in          = req_item.value;
               found_in        = 1'b0;
               rd_idx_in       = '0;
               rsp_valid_in    = 1'b1;
               rsp_in.status   = STAT_DONE;
               rsp_in.position = '0;
               rsp_in.length   = POS_W'(count_ff);
               rsp_in.last     = 1'b1;
               unique case (req_item.operation)
                  OP_APPEND: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_in.length = POS_W'(count_ff + CNT_W'(1));
                     end
                  end
                  OP_FIND, OP_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_in.status = STAT_NOT_FOUND;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                     // Unused code: list unchanged, done beat.
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (op_ff == OP_FIND) begin
               // Hold back each match until the next one shows it was not last.
               if (match) begin
                  if (found_ff) begin
                     rsp_valid_in    = 1'b1;
                     rsp_in.status   = STAT_MATCH;
                     rsp_in.position = pend_pos_ff;
                     rsp_in.length   = POS_W'(count_ff);
                     rsp_in.last     = 1'b0;
                  end
                  found_in    = 1'b1;
                  pend_pos_in = POS_W'(CNT_W'(da_ff) + CNT_W'(1));
               end
            end else begin
               // After the first match, every later entry moves up one place.
               if (dv_ff && found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = da_ff - ADDR_W'(1);
                  wr_data = rd_data;
               end else if (match) begin
                  found_in = 1'b1;
               end
            end
            if (finish) begin
               state_in = ST_FINAL;
            end
         end

         ST_FINAL: begin
            rsp_valid_in    = 1'b1;
            rsp_in.last     = 1'b1;
            rsp_in.length   = POS_W'(count_ff);
            rsp_in.position = '0;
            if (!found_ff) begin
               rsp_in.status = STAT_NOT_FOUND;
            end else if (op_ff == OP_FIND) begin
               rsp_in.status   = STAT_MATCH;
               rsp_in.position = pend_pos_ff;
            end else begin
               rsp_in.status = STAT_DONE;
               count_in      = count_ff - CNT_W'(1);
               rsp_in.length = POS_W'(count_ff - CNT_W'(1));
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         dv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         dv_ff        <= dv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      da_ff       <= da_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      pend_pos_ff <= pend_pos_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== tb/ordered_value_list_test.sv =====
`timescale 1ns / 1ps

module ordered_value_list_test;
   import ovl_pkg::*;

   // The fourth operation code is not used by the block and must be ignored.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 405;
   localparam int MAX_GAP      = 3;
   localparam int DRAIN_CYCLES = CAPACITY + 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MINUS_ONE     = 32'hFFFF_FFFF;

   typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_kind_type;

   // Keeps a mirror of the list and the beats that the block still owes.
   class value_list_scoreboard;
      logic [DATA_W-1:0] list_mirror[$];
      ovl_rsp_type       expected_beats[$];
      int mismatches, unexpected, checked;
      int appends, full_hits, finds, match_beats, longest_run;
      int removes, remove_misses, unused, longest_list;

      function void expect_beat(logic [STAT_W-1:0] status, logic [POS_W-1:0] position,
                                logic last);
         ovl_rsp_type beat;
         beat.status   = status;
         beat.position = position;
         beat.length   = POS_W'(list_mirror.size());
         beat.last     = last;
         expected_beats.push_back(beat);
      endfunction

      // Applies an accepted request to the mirror and queues the beats it causes.
      function void note_request(ovl_req_type req);
         int hits[$];
         int first;
         first = -1;
         case (req.operation)
            OP_APPEND: begin
               appends++;
               if (list_mirror.size() >= CAPACITY) begin
                  full_hits++;
                  expect_beat(STAT_FULL, '0, 1'b1);
               end else begin
                  list_mirror.push_back(req.value);
                  if (list_mirror.size() > longest_list) longest_list = list_mirror.size();
                  expect_beat(STAT_DONE, '0, 1'b1);
               end
            end
            OP_FIND: begin
               finds++;
               foreach (list_mirror[i])
                  if (list_mirror[i] == req.value) hits.push_back(i);
               if (hits.size() == 0) begin
                  expect_beat(STAT_NOT_FOUND, '0, 1'b1);
               end else begin
                  match_beats += hits.size();
                  if (hits.size() > longest_run) longest_run = hits.size();
                  foreach (hits[k])
                     expect_beat(STAT_MATCH, POS_W'(hits[k] + 1), k == hits.size() - 1);
               end
            end
            OP_REMOVE: begin
               removes++;
               for (int i = 0; i < list_mirror.size() && first < 0; i++)
                  if (list_mirror[i] == req.value) first = i;
               if (first >= 0) begin
                  list_mirror.delete(first);
                  expect_beat(STAT_DONE, '0, 1'b1);
               end else begin
                  remove_misses++;
                  expect_beat(STAT_NOT_FOUND, '0, 1'b1);
               end
            end
            default: begin
               unused++;
               expect_beat(STAT_DONE, '0, 1'b1);
            end
         endcase
      endfunction

      // Compares one result beat against the oldest expected beat.
      function void check_beat(ovl_rsp_type got);
         ovl_rsp_type want;
         checked++;
         if (expected_beats.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= REPORT_LIMIT)
               $display("unexpected beat: status %0d position %0d length %0d last %0d",
                        got.status, got.position, got.length, got.last);
            return;
         end
         want = expected_beats.pop_front();
         if (got.status !== want.status || got.position !== want.position ||
             got.length !== want.length || got.last !== want.last) begin
            mismatches++;
            if (mismatches + unexpected <= REPORT_LIMIT)
               $display("beat mismatch: expected status %0d position %0d length %0d last %0d, %s",
                        want.status, want.position, want.length, want.last,
                        $sformatf("got status %0d position %0d length %0d last %0d",
                                  got.status, got.position, got.length, got.last));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   ovl_req_type req_item = '0;
   logic        rsp_strobe;
   ovl_rsp_type rsp_item;

   value_list_scoreboard sb = new();
   int unsigned          cycle_count = 0;
   logic [DATA_W-1:0]    key_pool[4];
   int                   pool_size = 1;
   bit                   gaps_on = 1'b1;

   ordered_value_list dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #2 clock = ~clock;

   // Every strobed beat is taken at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_beat(rsp_item);
   end

   // Guard against a hang anywhere in the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // Presents one request beat after an optional gap and waits until it is taken.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
      int          gap;
      ovl_req_type item;
      gap            = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      item.operation = op;
      item.value     = value;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(item);
   endtask

   // Keys come mostly from a small pool or from the list itself, so finds and
   // removes hit often; the rest are fully random patterns.
   function automatic logic [DATA_W-1:0] pick_value();
      int roll;
      int count;
      roll  = $urandom_range(0, 99);
      count = sb.list_mirror.size();
      if (roll < 50) return key_pool[$urandom_range(0, pool_size - 1)];
      if (roll < 75 && count > 0) return sb.list_mirror[$urandom_range(0, count - 1)];
      return $urandom();
   endfunction

   // The operation mix depends on whether the phase grows, churns or shrinks the list.
   function automatic logic [OP_W-1:0] pick_operation(phase_kind_type kind);
      int roll;
      int append_pct;
      int find_pct;
      roll = $urandom_range(0, 99);
      case (kind)
         PH_FILL:  begin append_pct = 85; find_pct = 8;  end
         PH_MIXED: begin append_pct = 40; find_pct = 30; end
         default:  begin append_pct = 12; find_pct = 35; end
      endcase
      if (roll < append_pct) return OP_APPEND;
      if (roll < append_pct + find_pct) return OP_FIND;
      if (roll < 97) return OP_REMOVE;
      return OP_UNUSED;
   endfunction

   initial begin
      int             sent;
      int             phase;
      int             phase_len;
      phase_kind_type kind;
      sent  = 0;
      phase = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, extreme values, duplicates, misses, head and tail removal.
      send_request(OP_FIND, 32'h0);
      send_request(OP_REMOVE, 32'h0);
      send_request(OP_UNUSED, MINUS_ONE);
      send_request(OP_APPEND, MOST_NEGATIVE);
      send_request(OP_APPEND, MOST_POSITIVE);
      send_request(OP_APPEND, 32'h0);
      send_request(OP_APPEND, MINUS_ONE);
      send_request(OP_APPEND, MOST_NEGATIVE);
      send_request(OP_APPEND, 32'h5555_5555);
      send_request(OP_APPEND, 32'hAAAA_AAAA);
      send_request(OP_FIND, MOST_NEGATIVE);
      send_request(OP_FIND, MOST_POSITIVE);
      send_request(OP_FIND, 32'h1);
      send_request(OP_REMOVE, MOST_NEGATIVE);
      send_request(OP_FIND, MOST_NEGATIVE);
      send_request(OP_REMOVE, 32'h1234_5678);
      send_request(OP_REMOVE, 32'hAAAA_AAAA);
      send_request(OP_REMOVE, MOST_POSITIVE);
      send_request(OP_UNUSED, 32'h0);
      send_request(OP_FIND, 32'h0);
      send_request(OP_REMOVE, 32'h0);
      send_request(OP_REMOVE, MINUS_ONE);
      send_request(OP_REMOVE, MOST_NEGATIVE);
      send_request(OP_REMOVE, 32'h5555_5555);
      send_request(OP_FIND, 32'h5555_5555);

      // Random phases cycle through fill, churn and drain with fresh key pools.
      while (sent < RANDOM_ITEMS) begin
         kind      = phase_kind_type'(phase % 3);
         gaps_on   = ($urandom_range(0, 3) != 0);
         pool_size = $urandom_range(1, 4);
         foreach (key_pool[i]) begin
            case ($urandom_range(0, 7))
               0:       key_pool[i] = MOST_NEGATIVE;
               1:       key_pool[i] = MOST_POSITIVE;
               2:       key_pool[i] = MINUS_ONE;
               3:       key_pool[i] = '0;
               default: key_pool[i] = $urandom();
            endcase
         end
         phase_len = (kind == PH_FILL) ? $urandom_range(45, 55) : $urandom_range(30, 45);
         for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
            send_request(pick_operation(kind), pick_value());
            sent++;
         end
         phase++;
      end
      start <= 1'b0;

      // Wait for the owed beats, then watch a while longer for stray ones.
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d beats checked over %0d appends (%0d to a full list), %0d finds (%0d matches)",
               sb.checked, sb.appends, sb.full_hits, sb.finds, sb.match_beats);
      $display("up to %0d matches per key, %0d removes (%0d misses), %0d unused codes, %0d deep",
               sb.longest_run, sb.removes, sb.remove_misses, sb.unused, sb.longest_list);
      if (sb.mismatches + sb.unexpected == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatched and %0d unexpected beats", sb.mismatches, sb.unexpected);
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== ordered_value_list.f =====
src/ovl_pkg.sv
src/ovl_ram.sv
src/ordered_value_list.sv
tb/ordered_value_list_test.sv
